// ===== rtl/tlfs_pkg.sv =====
// Shared types and constants for the three-level feedback scheduler.
`timescale 1ns / 1ps
package tlfs_pkg;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_PICK = 2'd1,
    MODE_AGE  = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_ADD,
    FSM_PICK,
    FSM_AGE,
    FSM_MIGR,
    FSM_DONE
  } fsm_e;

  localparam logic [2:0] REG_L1_FLOOR = 3'd0;
  localparam logic [2:0] REG_L2_FLOOR = 3'd1;
  localparam logic [2:0] REG_PERIOD   = 3'd2;
  localparam logic [2:0] REG_STEP     = 3'd3;
  localparam logic [2:0] REG_CEILING  = 3'd4;

  localparam logic [7:0]  L1_FLOOR_RST = 8'd100;
  localparam logic [7:0]  L2_FLOOR_RST = 8'd50;
  localparam logic [15:0] PERIOD_RST   = 16'd1500;
  localparam logic [7:0]  STEP_RST     = 8'd10;
  localparam logic [7:0]  CEILING_RST  = 8'd149;

  // Level a priority earns under the given floors.
  function automatic logic [1:0] level_for(input logic [7:0] prio,
                                           input logic [7:0] f1,
                                           input logic [7:0] f2);
    logic [1:0] lvl;
    if (prio >= f1) begin
      lvl = 2'd1;
    end else if (prio >= f2) begin
      lvl = 2'd2;
    end else begin
      lvl = 2'd3;
    end
    return lvl;
  endfunction

endpackage

// ===== rtl/three_level_feedback_scheduler.sv =====
// Top level: ready table, entry sequencer and shared compare/age unit.
`timescale 1ns / 1ps
// Accept to result: add and pick scan every entry, then report; an aging pass scans
// every entry to age it, then again to migrate levels; an unused mode goes straight
// to the result. One entry is visited per cycle by the scan. The next word is taken
// in the cycle after the result; busy is high while a word is in work.
// Reset: all entries invalid, order counter zero, registers at reset values.
// done_o strobes for one cycle with the result; the receiver cannot stall.
module three_level_feedback_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  task_id_i,
  input  logic [7:0]  task_priority_i,
  input  logic [15:0] burst_estimate_i,
  input  logic [31:0] now_ticks_i,
  input  logic [1:0]  running_level_i,
  input  logic [15:0] running_burst_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [7:0]  picked_id_o,
  output logic [1:0]  picked_level_o,
  output logic        preempt_o
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] LAST = CW'(MAX_TASKS - 1);

  // configuration
  logic [7:0]  l1_q, l2_q, step_q, ceil_q;
  logic [15:0] period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q     <= tlfs_pkg::L1_FLOOR_RST;
      l2_q     <= tlfs_pkg::L2_FLOOR_RST;
      period_q <= tlfs_pkg::PERIOD_RST;
      step_q   <= tlfs_pkg::STEP_RST;
      ceil_q   <= tlfs_pkg::CEILING_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tlfs_pkg::REG_L1_FLOOR: l1_q     <= cfg_data_i[7:0];
        tlfs_pkg::REG_L2_FLOOR: l2_q     <= cfg_data_i[7:0];
        tlfs_pkg::REG_PERIOD:   period_q <= cfg_data_i;
        tlfs_pkg::REG_STEP:     step_q   <= cfg_data_i[7:0];
        tlfs_pkg::REG_CEILING:  ceil_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // entry table (valid bits reset, payload not)
  logic [MAX_TASKS-1:0] valid_q;
  logic [7:0]  id_q     [MAX_TASKS];
  logic [15:0] burst_q  [MAX_TASKS];
  logic [7:0]  prio_q   [MAX_TASKS];
  logic [31:0] waited_q [MAX_TASKS];
  logic [31:0] wstart_q [MAX_TASKS];
  logic [1:0]  level_q  [MAX_TASKS];
  logic [15:0] order_q  [MAX_TASKS];
  logic [15:0] ocnt_q;

  // latched input word
  tlfs_pkg::mode_e mode_q;
  logic [7:0]  tid_q, tprio_q;
  logic [15:0] tburst_q, rburst_q;
  logic [31:0] now_q;
  logic [1:0]  rlevel_q;

  tlfs_pkg::fsm_e st_q, st_d;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] idx;
  assign idx = cnt_q[IW-1:0];

  // scan results
  logic          found_q;           // free slot or candidate found
  logic [IW-1:0] best_q;
  logic [1:0]    blvl_q;            // level of best candidate
  logic [15:0]   bkey_q;            // burst, priority or age
  logic [7:0]    bid_q;
  logic          pre_q;
  logic [1:0]    status_q;

  wire accept = start && !busy;
  assign busy = (st_q != tlfs_pkg::FSM_IDLE);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      tlfs_pkg::FSM_IDLE: if (accept) begin
        case (tlfs_pkg::mode_e'(mode_i))
          tlfs_pkg::MODE_ADD:  st_d = tlfs_pkg::FSM_ADD;
          tlfs_pkg::MODE_PICK: st_d = tlfs_pkg::FSM_PICK;
          tlfs_pkg::MODE_AGE:  st_d = tlfs_pkg::FSM_AGE;
          default:             st_d = tlfs_pkg::FSM_DONE;
        endcase
      end
      tlfs_pkg::FSM_ADD, tlfs_pkg::FSM_PICK, tlfs_pkg::FSM_MIGR:
        if (cnt_q == LAST) st_d = tlfs_pkg::FSM_DONE;
      tlfs_pkg::FSM_AGE: if (cnt_q == LAST) st_d = tlfs_pkg::FSM_MIGR;
      tlfs_pkg::FSM_DONE: st_d = tlfs_pkg::FSM_IDLE;
      default: st_d = tlfs_pkg::FSM_IDLE;
    endcase
  end

  // shared per-entry unit: candidate compare for pick
  logic [15:0] age_i, ckey;
  logic        cand_better;
  always_comb begin
    age_i = ocnt_q - order_q[idx];
    case (level_q[idx])
      2'd1:    ckey = burst_q[idx];
      2'd2:    ckey = {8'd0, prio_q[idx]};
      default: ckey = age_i;
    endcase
    cand_better = 1'b0;
    if (valid_q[idx]) begin
      if (!found_q || level_q[idx] < blvl_q) begin
        cand_better = 1'b1;
      end else if (level_q[idx] == blvl_q) begin
        case (blvl_q)
          2'd1: cand_better = (ckey < bkey_q) ||
                              (ckey == bkey_q && id_q[idx] < bid_q);
          2'd2: cand_better = (ckey > bkey_q) ||
                              (ckey == bkey_q && id_q[idx] < bid_q);
          default: cand_better = ckey > bkey_q;
        endcase
      end
    end
  end

  // aging arithmetic on the visited entry
  logic [32:0] sum;
  logic [31:0] waited_n;
  logic [8:0]  psum;
  logic [7:0]  prio_n;
  logic        boost;
  always_comb begin
    sum      = {1'b0, waited_q[idx]} + {1'b0, now_q - wstart_q[idx]};
    waited_n = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    boost    = waited_n >= {16'd0, period_q};
    psum     = {1'b0, prio_q[idx]} + {1'b0, step_q};
    prio_n   = (psum > {1'b0, ceil_q}) ? ceil_q : psum[7:0];
  end

  logic [1:0] want;
  logic       moves;
  assign want  = tlfs_pkg::level_for(prio_q[idx], l1_q, l2_q);
  assign moves = valid_q[idx] && level_q[idx] != 2'd1 && want < level_q[idx];

  function automatic logic running_lvl_hit(input logic [1:0] rl, input logic [1:0] w,
                                           input logic [15:0] b, input logic [15:0] rb);
    logic h;
    h = (rl == 2'd3) || (rl == 2'd2 && w == 2'd1) ||
        (rl == 2'd1 && w == 2'd1 && b < rb);
    return h;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= tlfs_pkg::FSM_IDLE;
      cnt_q    <= '0;
      valid_q  <= '0;
      ocnt_q   <= '0;
      found_q  <= 1'b0;
      pre_q    <= 1'b0;
      status_q <= tlfs_pkg::ST_OK;
      best_q   <= '0;
      blvl_q   <= '0;
      mode_q   <= tlfs_pkg::MODE_NOP;
    end else begin
      st_q <= st_d;
      case (st_q)
        tlfs_pkg::FSM_IDLE: begin
          cnt_q    <= '0;
          found_q  <= 1'b0;
          pre_q    <= 1'b0;
          status_q <= tlfs_pkg::ST_OK;
          if (accept) mode_q <= tlfs_pkg::mode_e'(mode_i);
        end
        tlfs_pkg::FSM_ADD: begin
          cnt_q <= cnt_q + 1'b1;
          if (!found_q && !valid_q[idx]) begin
            found_q <= 1'b1;
            best_q  <= idx;
          end
          if (cnt_q == LAST) begin
            if (found_q || !valid_q[idx]) begin
              valid_q[found_q ? best_q : idx] <= 1'b1;
              ocnt_q <= ocnt_q + 16'd1;
            end else begin
              status_q <= tlfs_pkg::ST_FULL;
            end
          end
        end
        tlfs_pkg::FSM_PICK: begin
          cnt_q <= cnt_q + 1'b1;
          if (cand_better) begin
            found_q <= 1'b1;
            best_q  <= idx;
            blvl_q  <= level_q[idx];
            bkey_q  <= ckey;
            bid_q   <= id_q[idx];
          end
        end
        tlfs_pkg::FSM_AGE: begin
          cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + 1'b1;
        end
        tlfs_pkg::FSM_MIGR: begin
          cnt_q <= cnt_q + 1'b1;
          if (moves) begin
            if (running_lvl_hit(rlevel_q, want, burst_q[idx], rburst_q)) pre_q <= 1'b1;
          end
        end
        tlfs_pkg::FSM_DONE: begin
          if (mode_q == tlfs_pkg::MODE_PICK) begin
            if (found_q) valid_q[best_q] <= 1'b0;
            else status_q <= tlfs_pkg::ST_EMPTY;
          end
        end
        default: ;
      endcase
    end
  end

  // payload writes
  logic [IW-1:0] add_slot;
  assign add_slot = found_q ? best_q : idx;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tid_q    <= task_id_i;
      tprio_q  <= task_priority_i;
      tburst_q <= burst_estimate_i;
      now_q    <= now_ticks_i;
      rlevel_q <= running_level_i;
      rburst_q <= running_burst_i;
    end
    if (st_q == tlfs_pkg::FSM_ADD && cnt_q == LAST && (found_q || !valid_q[idx])) begin
      id_q[add_slot]     <= tid_q;
      prio_q[add_slot]   <= tprio_q;
      burst_q[add_slot]  <= tburst_q;
      wstart_q[add_slot] <= now_q;
      waited_q[add_slot] <= 32'd0;
      level_q[add_slot]  <= tlfs_pkg::level_for(tprio_q, l1_q, l2_q);
      order_q[add_slot]  <= ocnt_q;
    end
    if (st_q == tlfs_pkg::FSM_AGE && valid_q[idx]) begin
      wstart_q[idx] <= now_q;
      waited_q[idx] <= boost ? waited_n - {16'd0, period_q} : waited_n;
      if (boost) prio_q[idx] <= prio_n;
    end
    if (st_q == tlfs_pkg::FSM_MIGR && moves) level_q[idx] <= want;
  end

  // result word
  always_comb begin
    done_o         = (st_q == tlfs_pkg::FSM_DONE);
    status_o       = status_q;
    picked_id_o    = 8'd0;
    picked_level_o = 2'd0;
    preempt_o      = 1'b0;
    if (mode_q == tlfs_pkg::MODE_PICK) begin
      if (found_q) begin
        picked_id_o    = bid_q;
        picked_level_o = blvl_q;
      end else begin
        status_o = tlfs_pkg::ST_EMPTY;
      end
    end
    if (mode_q == tlfs_pkg::MODE_AGE) preempt_o = pre_q;
  end

  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("not idle after result");
  a_pick_lvl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != tlfs_pkg::ST_OK) |-> picked_level_o == 2'd0)
    else $error("level reported on failed item");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the three-level feedback scheduler.
`timescale 1ns / 1ps
module tb;

  localparam int TABLE_SIZE = 16;
  localparam int SETTLE     = 2 * TABLE_SIZE + 8;

  typedef struct packed {
    tlfs_pkg::status_e st;
    logic [7:0] id;
    logic [1:0] lvl;
    logic       pre;
  } sched_res_t;

  // Ready-table predictor plus the queue of results it still owes.
  class sched_board;
    logic [7:0]  f1 = tlfs_pkg::L1_FLOOR_RST, f2 = tlfs_pkg::L2_FLOOR_RST;
    logic [7:0]  step = tlfs_pkg::STEP_RST;
    logic [7:0]  ceil = tlfs_pkg::CEILING_RST;
    logic [15:0] period = tlfs_pkg::PERIOD_RST;
    bit          vld [TABLE_SIZE];
    logic [7:0]  tid [TABLE_SIZE];
    logic [7:0]  prio [TABLE_SIZE];
    logic [15:0] burst [TABLE_SIZE];
    logic [31:0] waited [TABLE_SIZE];
    logic [31:0] since [TABLE_SIZE];
    logic [1:0]  lvl [TABLE_SIZE];
    logic [15:0] seq [TABLE_SIZE];
    logic [15:0] seq_ctr = '0;
    sched_res_t  owed [$];
    int          errors = 0;

    function logic [1:0] place(logic [7:0] p);
      if (p >= f1) return 2'd1;
      if (p >= f2) return 2'd2;
      return 2'd3;
    endfunction

    // a ranks ahead of b within level l
    function bit ahead(int a, int b, logic [1:0] l);
      logic [15:0] age_a, age_b;
      age_a = seq_ctr - seq[a];
      age_b = seq_ctr - seq[b];
      if (l == 2'd1) begin
        if (burst[a] != burst[b]) return burst[a] < burst[b];
        return tid[a] < tid[b];
      end
      if (l == 2'd2) begin
        if (prio[a] != prio[b]) return prio[a] > prio[b];
        return tid[a] < tid[b];
      end
      return age_a > age_b;
    endfunction

    function void note_word(tlfs_pkg::mode_e m, logic [7:0] id, logic [7:0] p,
                            logic [15:0] b, logic [31:0] now, logic [1:0] rl,
                            logic [15:0] rb);
      sched_res_t r;
      int slot, best;
      logic [32:0] sum;
      logic [8:0] boosted;
      logic [1:0] want;
      r = '{tlfs_pkg::ST_OK, 8'd0, 2'd0, 1'b0};
      case (m)
        tlfs_pkg::MODE_ADD: begin
          slot = -1;
          for (int i = 0; i < TABLE_SIZE; i++)
            if (!vld[i] && slot < 0) slot = i;
          if (slot < 0) begin
            r.st = tlfs_pkg::ST_FULL;
          end else begin
            vld[slot] = 1; tid[slot] = id; prio[slot] = p; burst[slot] = b;
            since[slot] = now; waited[slot] = '0; lvl[slot] = place(p);
            seq[slot] = seq_ctr;
            seq_ctr++;
          end
        end
        tlfs_pkg::MODE_PICK: begin
          r.st = tlfs_pkg::ST_EMPTY;
          for (int l = 1; l <= 3 && r.st == tlfs_pkg::ST_EMPTY; l++) begin
            best = -1;
            for (int i = 0; i < TABLE_SIZE; i++)
              if (vld[i] && lvl[i] == 2'(l) && (best < 0 || ahead(i, best, 2'(l))))
                best = i;
            if (best >= 0) begin
              vld[best] = 0;
              r = '{tlfs_pkg::ST_OK, tid[best], 2'(l), 1'b0};
            end
          end
        end
        tlfs_pkg::MODE_AGE: begin
          for (int i = 0; i < TABLE_SIZE; i++) begin
            if (!vld[i]) continue;
            sum = {1'b0, waited[i]} + {1'b0, 32'(now - since[i])};
            waited[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            since[i] = now;
            if (waited[i] >= period) begin
              boosted = prio[i] + step;
              prio[i] = (boosted > ceil) ? ceil : boosted[7:0];
              waited[i] -= period;
            end
          end
          for (int i = 0; i < TABLE_SIZE; i++) begin
            if (!vld[i] || lvl[i] == 2'd1) continue;
            want = place(prio[i]);
            if (want >= lvl[i]) continue;
            lvl[i] = want;
            if (rl == 2'd3) r.pre = 1;
            else if (rl == 2'd2 && want == 2'd1) r.pre = 1;
            else if (rl == 2'd1 && want == 2'd1 && burst[i] < rb) r.pre = 1;
          end
        end
        default: ;
      endcase
      owed.push_back(r);
    endfunction

    function void check_word(sched_res_t got);
      sched_res_t exp;
      if (owed.size() == 0) begin
        $display("%0t: unexpected word st=%0d id=%0d lvl=%0d pre=%0b",
                 $time, got.st, got.id, got.lvl, got.pre);
        errors++;
        return;
      end
      exp = owed.pop_front();
      if (got.st !== exp.st) begin
        $display("%0t: status exp %0d got %0d", $time, exp.st, got.st); errors++;
      end
      if (got.id !== exp.id) begin
        $display("%0t: picked_id exp %0d got %0d", $time, exp.id, got.id); errors++;
      end
      if (got.lvl !== exp.lvl) begin
        $display("%0t: picked_level exp %0d got %0d", $time, exp.lvl, got.lvl); errors++;
      end
      if (got.pre !== exp.pre) begin
        $display("%0t: preempt exp %0b got %0b", $time, exp.pre, got.pre); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0, rst_ni = 0, start = 0, cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic [1:0]  mode_i = tlfs_pkg::MODE_NOP;
  logic [7:0]  task_id_i = '0, task_priority_i = '0;
  logic [15:0] burst_estimate_i = '0, running_burst_i = '0;
  logic [31:0] now_ticks_i = '0;
  logic [1:0]  running_level_i = '0;
  logic        busy, done_o, preempt_o;
  logic [1:0]  status_o, picked_level_o;
  logic [7:0]  picked_id_o;

  sched_board  sb = new();
  int          idle_pct = 0;
  logic [31:0] tick = '0;

  three_level_feedback_scheduler #(.MAX_TASKS(TABLE_SIZE)) i_dut (.*);

  initial forever #4 clk_i = ~clk_i;

  // Outputs only move on rising edges, so mid-cycle sampling is race free.
  always @(negedge clk_i)
    if (rst_ni && done_o)
      sb.check_word('{tlfs_pkg::status_e'(status_o), picked_id_o, picked_level_o,
                      preempt_o});

  // Present one word and hold it until taken; caller sits just after a rising edge.
  task automatic issue(tlfs_pkg::mode_e m, logic [7:0] id, logic [7:0] p,
                       logic [15:0] b, logic [31:0] now, logic [1:0] rl,
                       logic [15:0] rb);
    bit was_idle;
    start <= 1; mode_i <= m; task_id_i <= id; task_priority_i <= p;
    burst_estimate_i <= b; now_ticks_i <= now; running_level_i <= rl;
    running_burst_i <= rb;
    do begin
      @(negedge clk_i);
      was_idle = !busy;
      @(posedge clk_i);
    end while (!was_idle);
    sb.note_word(m, id, p, b, now, rl, rb);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Hold off new words until the table has answered everything.
  task automatic drain();
    start <= 0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      tlfs_pkg::REG_L1_FLOOR: sb.f1 = val[7:0];
      tlfs_pkg::REG_L2_FLOOR: sb.f2 = val[7:0];
      tlfs_pkg::REG_PERIOD:   sb.period = val;
      tlfs_pkg::REG_STEP:     sb.step = val[7:0];
      default:                sb.ceil = val[7:0];
    endcase
  endtask

  task automatic set_regs(logic [7:0] a, logic [7:0] b, logic [15:0] per,
                          logic [7:0] stp, logic [7:0] c);
    cfg_write(tlfs_pkg::REG_L1_FLOOR, {8'd0, a});
    cfg_write(tlfs_pkg::REG_L2_FLOOR, {8'd0, b});
    cfg_write(tlfs_pkg::REG_PERIOD, per);
    cfg_write(tlfs_pkg::REG_STEP, {8'd0, stp});
    cfg_write(tlfs_pkg::REG_CEILING, {8'd0, c});
  endtask

  // Mostly add/pick/age with tick counts that mostly move forward; ties are common.
  task automatic random_words(int n);
    tlfs_pkg::mode_e m;
    int    r;
    logic [7:0]  id;
    logic [15:0] b;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      m = (r < 42) ? tlfs_pkg::MODE_ADD : (r < 72) ? tlfs_pkg::MODE_PICK :
          (r < 96) ? tlfs_pkg::MODE_AGE : tlfs_pkg::MODE_NOP;
      id = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
      b  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
      if ($urandom_range(19) == 0) tick = $urandom;
      else tick += $urandom_range(0, 2500);
      issue(m, id, 8'($urandom), b, tick, 2'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty pick, unused mode, field extremes, level floors, full table.
    issue(tlfs_pkg::MODE_PICK, 8'd7, 8'd0, 16'd0, 32'd0, 2'd0, 16'd0);
    issue(tlfs_pkg::MODE_NOP, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 2'd3, 16'hFFFF);
    issue(tlfs_pkg::MODE_ADD, 8'hFF, 8'hFF, 16'hFFFF, 32'd0, 2'd0, 16'd0);
    issue(tlfs_pkg::MODE_ADD, 8'h00, 8'h00, 16'h0000, 32'd0, 2'd0, 16'd0);
    issue(tlfs_pkg::MODE_ADD, 8'd10, 8'd100, 16'd5, 32'd0, 2'd0, 16'd0);
    issue(tlfs_pkg::MODE_ADD, 8'd11, 8'd99, 16'd5, 32'd0, 2'd0, 16'd0);
    issue(tlfs_pkg::MODE_ADD, 8'd12, 8'd50, 16'd5, 32'd0, 2'd0, 16'd0);
    issue(tlfs_pkg::MODE_ADD, 8'd13, 8'd49, 16'd5, 32'd0, 2'd0, 16'd0);
    for (int i = 0; i < 11; i++)  // the last one finds the table full
      issue(tlfs_pkg::MODE_ADD, 8'(i), 8'(i * 23), 16'(i % 3), 32'hFFFF_FF00, 2'd0,
            16'd0);
    // Tick wraps past zero; waited saturates on the third pass.
    issue(tlfs_pkg::MODE_AGE, 8'd0, 8'd0, 16'd0, 32'd5000, 2'd1, 16'hFFFF);
    issue(tlfs_pkg::MODE_AGE, 8'd0, 8'd0, 16'd0, 32'hFFFF_0000, 2'd3, 16'd0);
    issue(tlfs_pkg::MODE_AGE, 8'd0, 8'd0, 16'd0, 32'h7FFF_0000, 2'd2, 16'd0);
    for (int i = 0; i < 4; i++)
      issue(tlfs_pkg::MODE_PICK, 8'd0, 8'd0, 16'd0, 32'd0, 2'd0, 16'd0);
    drain();

    // Phase sweep: each phase sets the registers (extremes included) and idle rate.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  set_regs(8'd100, 8'd50, 16'd1500, 8'd10, 8'd149); end
        1: begin idle_pct = 69; set_regs(8'd255, 8'd0, 16'd1, 8'd255, 8'd255); end
        2: begin idle_pct = 0;  set_regs(8'd0, 8'd255, 16'd65535, 8'd0, 8'd0); end
        3: begin idle_pct = 22; set_regs(8'd200, 8'd120, 16'd800, 8'd30, 8'd220); end
        4: begin idle_pct = 69; set_regs(8'($urandom), 8'($urandom),
                                        16'($urandom_range(1, 4000)), 8'($urandom),
                                        8'($urandom)); end
        default: begin idle_pct = 22; set_regs(8'd160, 8'd60, 16'd2000, 8'd25, 8'd200); end
      endcase
      random_words(90);
      drain();
    end

    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("[three_level_feedback_scheduler] OK");
    else
      $display("[three_level_feedback_scheduler] ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("[three_level_feedback_scheduler] ERROR");
    $finish;
  end

endmodule
